[hw/rtl/tip_pkg.sv]
`timescale 1ns / 1ps

// Shared types, constants and helpers of the text to integer parser.
package tip_pkg;

   // Field widths.
   localparam int unsigned CHAR_WIDTH     = 8;
   localparam int unsigned VALUE_WIDTH    = 64;
   localparam int unsigned STATUS_WIDTH   = 3;
   localparam int unsigned CSR_ADDR_WIDTH = 4;
   localparam int unsigned CSR_DATA_WIDTH = 32;

   // Parse phase of the current string.
   typedef enum logic [1:0] {
      PH_SPACE,
      PH_SIGN,
      PH_DIGITS,
      PH_STOP
   } phase_type;

   // Result status codes.
   typedef enum logic [STATUS_WIDTH-1:0] {
      ST_OK    = 3'd0,
      ST_BAD   = 3'd1,
      ST_OVF   = 3'd2,
      ST_NODIG = 3'd3,
      ST_SIGN  = 3'd4
   } status_type;

   // Configuration register indexes.
   typedef enum logic [1:0] {
      REG_RADIX_HEX,
      REG_SIGNED_MODE,
      REG_WIDE_MODE,
      REG_FULL_POSITIVE_RANGE
   } reg_index_type;

   // Character codes.
   localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO    = 8'h30;
   localparam logic [CHAR_WIDTH-1:0] CHAR_NINE    = 8'h39;
   localparam logic [CHAR_WIDTH-1:0] CHAR_LOWER_A = 8'h61;
   localparam logic [CHAR_WIDTH-1:0] CHAR_LOWER_F = 8'h66;
   localparam logic [CHAR_WIDTH-1:0] CHAR_UPPER_A = 8'h41;
   localparam logic [CHAR_WIDTH-1:0] CHAR_UPPER_F = 8'h46;
   localparam logic [CHAR_WIDTH-1:0] CHAR_LOWER_X = 8'h78;
   localparam logic [CHAR_WIDTH-1:0] CHAR_UPPER_X = 8'h58;
   localparam logic [CHAR_WIDTH-1:0] CHAR_MINUS   = 8'h2D;
   localparam logic [CHAR_WIDTH-1:0] CHAR_PLUS    = 8'h2B;
   localparam logic [CHAR_WIDTH-1:0] CHAR_SPACE   = 8'h20;
   localparam logic [CHAR_WIDTH-1:0] CHAR_TAB     = 8'h09;
   localparam logic [CHAR_WIDTH-1:0] CHAR_CR      = 8'h0D;

   // Magnitude limits.
   localparam logic [VALUE_WIDTH-1:0] LIM_NEG_32 = 64'h0000_0000_8000_0000;
   localparam logic [VALUE_WIDTH-1:0] LIM_NEG_64 = 64'h8000_0000_0000_0000;
   localparam logic [VALUE_WIDTH-1:0] LIM_U32    = 64'h0000_0000_FFFF_FFFF;
   localparam logic [VALUE_WIDTH-1:0] LIM_U64    = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam logic [VALUE_WIDTH-1:0] LIM_S32    = 64'h0000_0000_7FFF_FFFF;
   localparam logic [VALUE_WIDTH-1:0] LIM_S64    = 64'h7FFF_FFFF_FFFF_FFFF;

   // A decoded digit.
   typedef struct packed {
      logic       ok;
      logic [3:0] val;
   } digit_type;

   // Decode one character as a digit of the selected base.
   function automatic digit_type decode_digit(logic [CHAR_WIDTH-1:0] c, logic hex);
      digit_type d;
      logic [CHAR_WIDTH-1:0] diff;
      d    = '{ok: 1'b0, val: 4'd0};
      diff = '0;
      if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
         diff = c - CHAR_ZERO;
         d    = '{ok: 1'b1, val: diff[3:0]};
      end else if (hex && c >= CHAR_LOWER_A && c <= CHAR_LOWER_F) begin
         diff = c - CHAR_LOWER_A + 8'd10;
         d    = '{ok: 1'b1, val: diff[3:0]};
      end else if (hex && c >= CHAR_UPPER_A && c <= CHAR_UPPER_F) begin
         diff = c - CHAR_UPPER_A + 8'd10;
         d    = '{ok: 1'b1, val: diff[3:0]};
      end
      return d;
   endfunction

endpackage

[hw/rtl/tip_req_if.sv]
`timescale 1ns / 1ps

// Character channel: one character of the string per transfer.
interface tip_req_if;
   logic                            valid;
   logic                            ready;
   logic [tip_pkg::CHAR_WIDTH-1:0]  ch;
   logic                            has_char;
   logic                            last;

   modport source (output valid, ch, has_char, last, input ready);
   modport sink   (input valid, ch, has_char, last, output ready);
endinterface

[hw/rtl/tip_rsp_if.sv]
`timescale 1ns / 1ps

// Result channel: one parsed integer per string.
interface tip_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [tip_pkg::VALUE_WIDTH-1:0]   value;
   logic [tip_pkg::STATUS_WIDTH-1:0]  status;
   logic                              leading_space;
   logic                              valid_res;

   modport source (output valid, value, status, leading_space, valid_res, input ready);
   modport sink   (input valid, value, status, leading_space, valid_res, output ready);
endinterface

[hw/rtl/text_to_integer_parser.sv]
`timescale 1ns / 1ps

// Streaming string to integer parser, decimal or hex, 32 or 64 bits.
// req carries one character per transfer; has_char low marks an item with
// no character, last marks the end of the string. rsp carries one result
// (value, status, leading_space, valid_res) per string, on its last item.
// The APB port sets radix, signed mode, width and positive range; write it
// only while no string is in progress.
// A result is offered once the last item has passed the input register and
// then the result register.
// Throughput: one character per cycle; the per-character multiply by ten or
// sixteen, the add and the limit compare fit in the single parse stage.
// When rsp stalls, one finished result waits in the result register while
// characters of the next string keep flowing; only a second last item waits.
// Reset clears the parse state, the registers to decimal, signed, 32 bits,
// and drops any pending character or result.
module text_to_integer_parser (
   input  logic                                clock,
   input  logic                                reset,
   tip_req_if.sink                             req,
   tip_rsp_if.source                           rsp,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [tip_pkg::CSR_ADDR_WIDTH-1:0]  paddr,
   input  logic [tip_pkg::CSR_DATA_WIDTH-1:0]  pwdata,
   output logic [tip_pkg::CSR_DATA_WIDTH-1:0]  prdata,
   output logic                                pready
);

   // What one character does to the parse state.
   typedef enum logic [3:0] {
      ACT_NONE,
      ACT_SPACE,
      ACT_NEG,
      ACT_SIGN_ERR,
      ACT_PLUS,
      ACT_PREFIX,
      ACT_BAD,
      ACT_FIRST,
      ACT_OVF,
      ACT_ACCUM
   } act_type;

   localparam int unsigned VW = tip_pkg::VALUE_WIDTH;

   // Configuration registers.
   logic                    radix_hex_ff;
   logic                    signed_mode_ff;
   logic                    wide_mode_ff;
   logic                    full_pos_ff;
   logic                    csr_write;
   tip_pkg::reg_index_type  csr_index;

   // Input register.
   logic                            in_valid_ff;
   logic [tip_pkg::CHAR_WIDTH-1:0]  in_ch_ff;
   logic                            in_has_ff;
   logic                            in_last_ff;
   logic                            adv;
   logic                            finish;

   // Parse state.
   tip_pkg::phase_type   phase_ff;
   tip_pkg::phase_type   phase_in;
   logic [VW-1:0]        acc_ff;
   logic [VW-1:0]        acc_in;
   logic                 neg_ff;
   logic                 neg_in;
   logic                 space_ff;
   logic                 space_in;
   logic [1:0]           dp_ff;
   logic [1:0]           dp_in;
   tip_pkg::status_type  stop_ff;
   tip_pkg::status_type  stop_in;

   // Character decode and arithmetic.
   act_type              act;
   tip_pkg::digit_type   dig;
   logic                 is_space;
   logic                 x_prefix;
   logic [VW-1:0]        lim;
   logic [VW+3:0]        scaled;
   logic [VW+3:0]        sum;
   logic                 ovf;

   // Result register.
   logic                 rsp_valid_ff;
   logic [VW-1:0]        res_mag_ff;
   logic [VW-1:0]        res_mag_in;
   logic                 res_neg_ff;
   logic                 res_wide_ff;
   tip_pkg::status_type  res_status_ff;
   tip_pkg::status_type  res_status_in;
   logic                 res_space_ff;
   logic [VW-1:0]        res_signed;

   // Configuration port: writes complete in the access phase.
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign csr_index = tip_pkg::reg_index_type'(paddr[3:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_hex_ff   <= 1'b0;
         signed_mode_ff <= 1'b1;
         wide_mode_ff   <= 1'b0;
         full_pos_ff    <= 1'b0;
      end else if (csr_write) begin
         unique case (csr_index)
            tip_pkg::REG_RADIX_HEX:           radix_hex_ff   <= pwdata[0];
            tip_pkg::REG_SIGNED_MODE:         signed_mode_ff <= pwdata[0];
            tip_pkg::REG_WIDE_MODE:           wide_mode_ff   <= pwdata[0];
            tip_pkg::REG_FULL_POSITIVE_RANGE: full_pos_ff    <= pwdata[0];
            default: ;
         endcase
      end
   end

   // Register read-back.
   always_comb begin
      prdata = '0;
      unique case (csr_index)
         tip_pkg::REG_RADIX_HEX:           prdata[0] = radix_hex_ff;
         tip_pkg::REG_SIGNED_MODE:         prdata[0] = signed_mode_ff;
         tip_pkg::REG_WIDE_MODE:           prdata[0] = wide_mode_ff;
         tip_pkg::REG_FULL_POSITIVE_RANGE: prdata[0] = full_pos_ff;
         default: ;
      endcase
   end

   // The parse stage moves unless a last item finds a stalled result register full.
   assign adv       = in_valid_ff && (!in_last_ff || !rsp_valid_ff || rsp.ready);
   assign finish    = adv && in_last_ff;
   assign req.ready = !in_valid_ff || adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req.ready) begin
         in_valid_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         in_ch_ff   <= req.ch;
         in_has_ff  <= req.has_char;
         in_last_ff <= req.last;
      end
   end

   // Character classes.
   assign is_space = (in_ch_ff == tip_pkg::CHAR_SPACE) ||
                     (in_ch_ff >= tip_pkg::CHAR_TAB && in_ch_ff <= tip_pkg::CHAR_CR);
   assign dig      = tip_pkg::decode_digit(in_ch_ff, radix_hex_ff);
   assign x_prefix = radix_hex_ff && (phase_ff == tip_pkg::PH_DIGITS) && (dp_ff == 2'd1) &&
                     (acc_ff == '0) &&
                     (in_ch_ff == tip_pkg::CHAR_LOWER_X || in_ch_ff == tip_pkg::CHAR_UPPER_X);

   // Magnitude limit for the current sign and mode.
   always_comb begin
      if (neg_ff) begin
         lim = wide_mode_ff ? tip_pkg::LIM_NEG_64 : tip_pkg::LIM_NEG_32;
      end else if (!signed_mode_ff || full_pos_ff) begin
         lim = wide_mode_ff ? tip_pkg::LIM_U64 : tip_pkg::LIM_U32;
      end else begin
         lim = wide_mode_ff ? tip_pkg::LIM_S64 : tip_pkg::LIM_S32;
      end
   end

   // Next accumulator value, wide enough that the limit compare is exact.
   always_comb begin
      if (radix_hex_ff) begin
         scaled = {acc_ff, 4'b0000};
      end else begin
         scaled = {1'b0, acc_ff, 3'b000} + {3'b000, acc_ff, 1'b0};
      end
      sum = scaled + {{VW{1'b0}}, dig.val};
      ovf = sum > {4'b0000, lim};
   end

   // Classify the character against the current phase.
   always_comb begin
      act = ACT_NONE;
      if (in_has_ff && phase_ff != tip_pkg::PH_STOP) begin
         if (phase_ff == tip_pkg::PH_SPACE && is_space) begin
            act = ACT_SPACE;
         end else if (phase_ff == tip_pkg::PH_SPACE && in_ch_ff == tip_pkg::CHAR_MINUS) begin
            act = signed_mode_ff ? ACT_NEG : ACT_SIGN_ERR;
         end else if (phase_ff == tip_pkg::PH_SPACE && in_ch_ff == tip_pkg::CHAR_PLUS) begin
            act = ACT_PLUS;
         end else if (x_prefix) begin
            act = ACT_PREFIX;
         end else if (!dig.ok) begin
            act = ACT_BAD;
         end else if (dp_ff == 2'd0) begin
            act = ACT_FIRST;
         end else if (ovf) begin
            act = ACT_OVF;
         end else begin
            act = ACT_ACCUM;
         end
      end
   end

   // Next phase.
   always_comb begin
      phase_in = phase_ff;
      unique case (act)
         ACT_NONE, ACT_SPACE, ACT_PREFIX: phase_in = phase_ff;
         ACT_NEG, ACT_PLUS:               phase_in = tip_pkg::PH_SIGN;
         ACT_SIGN_ERR, ACT_BAD, ACT_OVF:  phase_in = tip_pkg::PH_STOP;
         ACT_FIRST, ACT_ACCUM:            phase_in = tip_pkg::PH_DIGITS;
         default:                         phase_in = phase_ff;
      endcase
   end

   // Next accumulator, sign, whitespace flag, digit count and stop status.
   always_comb begin
      acc_in   = acc_ff;
      neg_in   = neg_ff;
      space_in = space_ff;
      dp_in    = dp_ff;
      stop_in  = stop_ff;
      unique case (act)
         ACT_SPACE:    space_in = 1'b1;
         ACT_NEG:      neg_in   = 1'b1;
         ACT_SIGN_ERR: stop_in  = tip_pkg::ST_SIGN;
         ACT_PREFIX:   dp_in    = 2'd2;
         ACT_BAD:      stop_in  = tip_pkg::ST_BAD;
         ACT_FIRST: begin
            acc_in = {{(VW-4){1'b0}}, dig.val};
            dp_in  = 2'd1;
         end
         ACT_OVF: begin
            acc_in  = lim;
            stop_in = tip_pkg::ST_OVF;
         end
         ACT_ACCUM: begin
            acc_in = sum[VW-1:0];
            dp_in  = 2'd2;
         end
         default: ;
      endcase
   end

   // Parse state: cleared after the last item of a string.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= tip_pkg::PH_SPACE;
         acc_ff   <= '0;
         neg_ff   <= 1'b0;
         space_ff <= 1'b0;
         dp_ff    <= 2'd0;
         stop_ff  <= tip_pkg::ST_OK;
      end else if (finish) begin
         phase_ff <= tip_pkg::PH_SPACE;
         acc_ff   <= '0;
         neg_ff   <= 1'b0;
         space_ff <= 1'b0;
         dp_ff    <= 2'd0;
         stop_ff  <= tip_pkg::ST_OK;
      end else if (adv) begin
         phase_ff <= phase_in;
         acc_ff   <= acc_in;
         neg_ff   <= neg_in;
         space_ff <= space_in;
         dp_ff    <= dp_in;
         stop_ff  <= stop_in;
      end
   end

   // Result status and magnitude from the updated state.
   always_comb begin
      if (phase_in == tip_pkg::PH_STOP) begin
         res_status_in = stop_in;
      end else if (phase_in == tip_pkg::PH_DIGITS) begin
         res_status_in = tip_pkg::ST_OK;
      end else begin
         res_status_in = tip_pkg::ST_NODIG;
      end
      if (res_status_in == tip_pkg::ST_SIGN || res_status_in == tip_pkg::ST_NODIG) begin
         res_mag_in = '0;
      end else begin
         res_mag_in = acc_in;
      end
   end

   // Result register: holds one result until its transfer.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (finish) begin
         res_mag_ff    <= res_mag_in;
         res_neg_ff    <= neg_in;
         res_wide_ff   <= wide_mode_ff;
         res_status_ff <= res_status_in;
         res_space_ff  <= space_in;
      end
   end

   // Apply the sign and the result width.
   assign res_signed        = res_neg_ff ? (~res_mag_ff + 64'd1) : res_mag_ff;
   assign rsp.valid         = rsp_valid_ff;
   assign rsp.value         = res_wide_ff ? res_signed : {32'd0, res_signed[31:0]};
   assign rsp.status        = res_status_ff;
   assign rsp.leading_space = res_space_ff;
   assign rsp.valid_res     = (res_status_ff == tip_pkg::ST_OK) && !res_space_ff;

   // A new result only comes from a last item leaving the parse stage.
   a_result_from_last: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(finish))
      else $error("result appeared without a last item");

   // The parse state is clean after the end of a string.
   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      finish |=> (phase_ff == tip_pkg::PH_SPACE) && (acc_ff == '0) && (dp_ff == 2'd0) &&
                 !neg_ff && !space_ff)
      else $error("parse state not cleared after last item");

   // The digit phase always has at least one digit character behind it.
   a_digits_counted: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == tip_pkg::PH_DIGITS) |-> (dp_ff != 2'd0))
      else $error("digit phase without digits");

   // A stopped parse always carries a reason.
   a_stop_reason: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == tip_pkg::PH_STOP) |-> (stop_ff != tip_pkg::ST_OK))
      else $error("stopped parse without a stop status");

endmodule

[test/parse_result_monitor.sv]
`timescale 1ns / 1ps

// Watches the character, result and register ports of the parser. It keeps
// its own copy of the parse state and register settings, works out the
// integer that each finished string must produce and compares every result
// transfer with the oldest one still owed.
module parse_result_monitor (
   input  logic                               clock,
   input  logic                               reset,
   tip_req_if                                 req,
   tip_rsp_if                                 rsp,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic                               pready,
   input  logic [tip_pkg::CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [tip_pkg::CSR_DATA_WIDTH-1:0] pwdata,
   output int                                 mismatches,
   output int                                 integers_due
);

   typedef struct packed {
      logic [tip_pkg::VALUE_WIDTH-1:0] value;
      tip_pkg::status_type             status;
      logic                            leading_space;
      logic                            valid_res;
   } parsed_integer_type;

   // Results owed by the parser, oldest first.
   parsed_integer_type pending_integers[$];

   // Register settings as last written.
   logic hex_digits;
   logic sign_mode;
   logic wide_result;
   logic full_range;

   // Parse state of the string in progress.
   logic [tip_pkg::VALUE_WIDTH-1:0] magnitude;
   tip_pkg::phase_type              parse_phase;
   logic                            minus_seen;
   logic                            blank_seen;
   logic [1:0]                      digits_taken;
   tip_pkg::status_type             halt_status;

   task automatic report_mismatch(input string field,
                                  input logic [tip_pkg::VALUE_WIDTH-1:0] got,
                                  input logic [tip_pkg::VALUE_WIDTH-1:0] want);
      mismatches++;
      $display("%0t: mismatch in %s: got %h, expected %h", $time, field, got, want);
   endtask

   // Queue one owed result behind the others.
   function automatic void owe_integer(input parsed_integer_type r);
      pending_integers.insert(pending_integers.size(), r);
   endfunction

   task automatic clear_string();
      magnitude    = '0;
      parse_phase  = tip_pkg::PH_SPACE;
      minus_seen   = 1'b0;
      blank_seen   = 1'b0;
      digits_taken = 2'd0;
      halt_status  = tip_pkg::ST_OK;
   endtask

   function automatic int digit_value(input logic [tip_pkg::CHAR_WIDTH-1:0] c);
      if (c >= tip_pkg::CHAR_ZERO && c <= tip_pkg::CHAR_NINE)
         return int'(c - tip_pkg::CHAR_ZERO);
      if (hex_digits && c >= tip_pkg::CHAR_LOWER_A && c <= tip_pkg::CHAR_LOWER_F)
         return int'(c - tip_pkg::CHAR_LOWER_A) + 10;
      if (hex_digits && c >= tip_pkg::CHAR_UPPER_A && c <= tip_pkg::CHAR_UPPER_F)
         return int'(c - tip_pkg::CHAR_UPPER_A) + 10;
      return -1;
   endfunction

   // Largest magnitude that the current sign and settings allow.
   function automatic logic [tip_pkg::VALUE_WIDTH-1:0] magnitude_bound();
      if (minus_seen)
         return wide_result ? tip_pkg::LIM_NEG_64 : tip_pkg::LIM_NEG_32;
      if (!sign_mode || full_range)
         return wide_result ? tip_pkg::LIM_U64 : tip_pkg::LIM_U32;
      return wide_result ? tip_pkg::LIM_S64 : tip_pkg::LIM_S32;
   endfunction

   // Advance the parse state by one character.
   task automatic consume_char(input logic [tip_pkg::CHAR_WIDTH-1:0] c);
      int                              d;
      logic [tip_pkg::VALUE_WIDTH-1:0] base;
      logic [tip_pkg::VALUE_WIDTH-1:0] bound;
      logic [tip_pkg::VALUE_WIDTH-1:0] digit;
      if (parse_phase == tip_pkg::PH_STOP)
         return;
      if (parse_phase == tip_pkg::PH_SPACE) begin
         if (c == tip_pkg::CHAR_SPACE || (c >= tip_pkg::CHAR_TAB && c <= tip_pkg::CHAR_CR)) begin
            blank_seen = 1'b1;
            return;
         end
         if (c == tip_pkg::CHAR_MINUS) begin
            if (!sign_mode) begin
               halt_status = tip_pkg::ST_SIGN;
               parse_phase = tip_pkg::PH_STOP;
            end else begin
               minus_seen  = 1'b1;
               parse_phase = tip_pkg::PH_SIGN;
            end
            return;
         end
         parse_phase = tip_pkg::PH_SIGN;
         if (c == tip_pkg::CHAR_PLUS)
            return;
      end
      // An x right after a single leading zero is the hex prefix.
      if (hex_digits && parse_phase == tip_pkg::PH_DIGITS && digits_taken == 2'd1 &&
          magnitude == '0 && (c == tip_pkg::CHAR_LOWER_X || c == tip_pkg::CHAR_UPPER_X)) begin
         digits_taken = 2'd2;
         return;
      end
      d = digit_value(c);
      if (d < 0) begin
         halt_status = tip_pkg::ST_BAD;
         parse_phase = tip_pkg::PH_STOP;
         return;
      end
      digit = tip_pkg::VALUE_WIDTH'(d);
      base  = hex_digits ? 64'd16 : 64'd10;
      if (digits_taken == 2'd0) begin
         magnitude = digit;
      end else begin
         bound = magnitude_bound();
         if (magnitude > bound / base || (magnitude == bound / base && digit > bound % base)) begin
            magnitude   = bound;
            halt_status = tip_pkg::ST_OVF;
            parse_phase = tip_pkg::PH_STOP;
            return;
         end
         magnitude = magnitude * base + digit;
      end
      if (digits_taken < 2'd2)
         digits_taken++;
      parse_phase = tip_pkg::PH_DIGITS;
   endtask

   // Form the result of the finished string and start a fresh one.
   task automatic close_string(output parsed_integer_type r);
      if (parse_phase == tip_pkg::PH_STOP)
         r.status = halt_status;
      else if (parse_phase == tip_pkg::PH_DIGITS)
         r.status = tip_pkg::ST_OK;
      else
         r.status = tip_pkg::ST_NODIG;
      if (r.status == tip_pkg::ST_SIGN || r.status == tip_pkg::ST_NODIG)
         r.value = '0;
      else if (minus_seen)
         r.value = '0 - magnitude;
      else
         r.value = magnitude;
      if (!wide_result)
         r.value[tip_pkg::VALUE_WIDTH-1:32] = '0;
      r.leading_space = blank_seen;
      r.valid_res     = (r.status == tip_pkg::ST_OK) && !blank_seen;
      clear_string();
   endtask

   always @(posedge clock) begin
      parsed_integer_type want;
      if (reset) begin
         hex_digits  = 1'b0;
         sign_mode   = 1'b1;
         wide_result = 1'b0;
         full_range  = 1'b0;
         mismatches  = 0;
         clear_string();
         pending_integers.delete();
      end else begin
         // Register writes.
         if (psel && penable && pwrite && pready) begin
            case (tip_pkg::reg_index_type'(paddr[tip_pkg::CSR_ADDR_WIDTH-1:2]))
               tip_pkg::REG_RADIX_HEX:           hex_digits  = pwdata[0];
               tip_pkg::REG_SIGNED_MODE:         sign_mode   = pwdata[0];
               tip_pkg::REG_WIDE_MODE:           wide_result = pwdata[0];
               tip_pkg::REG_FULL_POSITIVE_RANGE: full_range  = pwdata[0];
               default: ;
            endcase
         end
         // Result transfers against the oldest owed integer.
         if (rsp.valid && rsp.ready) begin
            if (pending_integers.size() == 0) begin
               report_mismatch("result with none owed", rsp.value, '0);
            end else begin
               want = pending_integers.pop_front();
               if (rsp.value !== want.value)
                  report_mismatch("value", rsp.value, want.value);
               if (rsp.status !== want.status)
                  report_mismatch("status", tip_pkg::VALUE_WIDTH'(rsp.status),
                                  tip_pkg::VALUE_WIDTH'(want.status));
               if (rsp.leading_space !== want.leading_space)
                  report_mismatch("leading_space", tip_pkg::VALUE_WIDTH'(rsp.leading_space),
                                  tip_pkg::VALUE_WIDTH'(want.leading_space));
               if (rsp.valid_res !== want.valid_res)
                  report_mismatch("valid_res", tip_pkg::VALUE_WIDTH'(rsp.valid_res),
                                  tip_pkg::VALUE_WIDTH'(want.valid_res));
            end
         end
         // Character transfers.
         if (req.valid && req.ready) begin
            if (req.has_char)
               consume_char(req.ch);
            if (req.last) begin
               close_string(want);
               owe_integer(want);
            end
         end
      end
      integers_due <= pending_integers.size();
   end

endmodule

[test/testbench.sv]
`timescale 1ns / 1ps

module testbench;

   localparam int ITEM_TARGET   = 550;
   localparam int QUIET_LIMIT   = 2000;
   localparam int SETTLE_CYCLES = 4;

   typedef logic [tip_pkg::CHAR_WIDTH-1:0] text_type[$];

   logic                               clock;
   logic                               reset;
   logic                               psel;
   logic                               penable;
   logic                               pwrite;
   logic [tip_pkg::CSR_ADDR_WIDTH-1:0] paddr;
   logic [tip_pkg::CSR_DATA_WIDTH-1:0] pwdata;
   logic [tip_pkg::CSR_DATA_WIDTH-1:0] prdata;
   logic                               pready;

   bit       gaps_on;
   logic [3:0] mode_now;
   int       sent_items;
   int       quiet_cycles;
   int       mismatches;
   int       integers_due;

   logic [tip_pkg::CHAR_WIDTH-1:0] blank_chars[6] = '{tip_pkg::CHAR_SPACE, tip_pkg::CHAR_TAB,
                                                      8'h0A, 8'h0B, 8'h0C, tip_pkg::CHAR_CR};
   string broken_texts[15] = '{"+", "-", "  ", "\t\n", "12 3", "+-5", "--5", "0x", "0X", "0xx",
                               "x5", "- 5", "5-", "0x-1", "\v\f7"};

   tip_req_if req_if ();
   tip_rsp_if rsp_if ();

   text_to_integer_parser dut (
      .clock   (clock),
      .reset   (reset),
      .req     (req_if),
      .rsp     (rsp_if),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   parse_result_monitor result_monitor (
      .clock        (clock),
      .reset        (reset),
      .req          (req_if),
      .rsp          (rsp_if),
      .psel         (psel),
      .penable      (penable),
      .pwrite       (pwrite),
      .pready       (pready),
      .paddr        (paddr),
      .pwdata       (pwdata),
      .mismatches   (mismatches),
      .integers_due (integers_due)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // The result side stalls at random while gaps are enabled.
   always @(posedge clock)
      rsp_if.ready <= !gaps_on || ($urandom_range(99) >= 32);

   // End the run when nothing has been transferred for too long.
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (psel && penable))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // Add one character at the end of a string.
   function automatic void append_char(ref text_type t, input logic [tip_pkg::CHAR_WIDTH-1:0] c);
      t.insert(t.size(), c);
   endfunction

   function automatic text_type from_text(input string s);
      text_type t;
      for (int i = 0; i < s.len(); i++)
         append_char(t, s[i]);
      return t;
   endfunction

   // A random byte.
   function automatic logic [tip_pkg::CHAR_WIDTH-1:0] pick_byte();
      return tip_pkg::CHAR_WIDTH'($urandom_range(255));
   endfunction

   // A random digit of the current base, hex letters in either case.
   function automatic logic [tip_pkg::CHAR_WIDTH-1:0] pick_digit();
      int v;
      v = $urandom_range(mode_now[tip_pkg::REG_RADIX_HEX] ? 15 : 9);
      if (v < 10)
         return tip_pkg::CHAR_ZERO + tip_pkg::CHAR_WIDTH'(v);
      return ($urandom_range(1) ? tip_pkg::CHAR_LOWER_A : tip_pkg::CHAR_UPPER_A) +
             tip_pkg::CHAR_WIDTH'(v - 10);
   endfunction

   // Write every register over the APB port, back to back.
   task automatic set_mode(input logic [3:0] mode);
      for (int i = 0; i < 4; i++) begin
         psel    <= 1'b1;
         penable <= 1'b0;
         pwrite  <= 1'b1;
         paddr   <= {tip_pkg::reg_index_type'(i), 2'b00};
         pwdata  <= {{(tip_pkg::CSR_DATA_WIDTH-1){1'b0}}, mode[i]};
         @(posedge clock);
         penable <= 1'b1;
         do @(posedge clock); while (!pready);
      end
      psel     <= 1'b0;
      penable  <= 1'b0;
      mode_now = mode;
   endtask

   // One character transfer, after an optional random gap.
   task automatic send_item(input logic [tip_pkg::CHAR_WIDTH-1:0] c, input logic has,
                            input logic fin);
      while (gaps_on && $urandom_range(99) < 32) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid    <= 1'b1;
      req_if.ch       <= c;
      req_if.has_char <= has;
      req_if.last     <= fin;
      do @(posedge clock); while (!req_if.ready);
      if (has || fin)
         sent_items++;
   endtask

   // Send a whole string; the end mark rides on the last character or on an
   // extra item without a character. Ignored items are mixed in now and then.
   task automatic send_text(input text_type t, input bit split_end);
      foreach (t[i]) begin
         if ($urandom_range(29) == 0)
            send_item(pick_byte(), 1'b0, 1'b0);
         send_item(t[i], 1'b1, !split_end && i == t.size() - 1);
      end
      if (split_end || t.size() == 0)
         send_item(pick_byte(), 1'b0, 1'b1);
   endtask

   // Stop sending and wait until every owed result has come out.
   task automatic drain();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (integers_due != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      text_type                        text;
      string                           digits;
      logic [tip_pkg::VALUE_WIDTH-1:0] bound;
      logic [tip_pkg::CHAR_WIDTH-1:0]  c;
      logic [3:0]                      presets[6];
      int                              kind;
      int                              string_count;
      bit                              negative;

      presets = '{4'b0000, 4'b1111, 4'b0010, 4'b1101, 4'b0110, 4'b1001};
      reset           = 1'b1;
      psel            = 1'b0;
      penable         = 1'b0;
      pwrite          = 1'b0;
      paddr           = '0;
      pwdata          = '0;
      req_if.valid    = 1'b0;
      req_if.ch       = '0;
      req_if.has_char = 1'b0;
      req_if.last     = 1'b0;
      gaps_on         = 1'b1;
      sent_items      = 0;
      mode_now        = 4'b0010;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed strings: decimal, signed, 32 bits.
      set_mode(4'b0010);
      send_text(from_text(""), 1'b0);
      send_item(8'h5A, 1'b0, 1'b0);
      send_text(from_text("7"), 1'b0);
      send_text(from_text(" \t+5"), 1'b0);
      send_text(from_text("-"), 1'b0);
      send_text(from_text("1x"), 1'b0);
      text.delete();
      append_char(text, 8'hFF);
      send_text(text, 1'b1);
      drain();
      // A minus sign while unsigned.
      set_mode(4'b0000);
      send_text(from_text("-3"), 1'b0);
      drain();
      // Hex, signed, 64 bits: lone prefix and a negative prefixed value.
      set_mode(4'b0111);
      send_text(from_text("0x"), 1'b0);
      send_text(from_text("-0XfF"), 1'b0);

      // Random strings, mostly well formed, in blocks that share one setting.
      string_count = 0;
      while (sent_items < ITEM_TARGET) begin
         if (string_count % 8 == 0) begin
            drain();
            set_mode(string_count / 8 < 6 ? presets[string_count / 8] : 4'($urandom_range(15)));
         end
         gaps_on <= !(sent_items >= 250 && sent_items < 370);
         text.delete();
         kind = $urandom_range(99);
         if (kind < 70) begin
            if ($urandom_range(9) == 0)
               repeat ($urandom_range(1, 2)) append_char(text, blank_chars[$urandom_range(5)]);
            case ($urandom_range(3))
               0: append_char(text, tip_pkg::CHAR_PLUS);
               1: append_char(text, tip_pkg::CHAR_MINUS);
               default: ;
            endcase
            negative = text.size() != 0 && text[text.size() - 1] == tip_pkg::CHAR_MINUS;
            if (mode_now[tip_pkg::REG_RADIX_HEX] && $urandom_range(2) == 0) begin
               append_char(text, tip_pkg::CHAR_ZERO);
               append_char(text, $urandom_range(1) ? tip_pkg::CHAR_LOWER_X
                                                   : tip_pkg::CHAR_UPPER_X);
            end
            if ($urandom_range(4) == 0)
               append_char(text, tip_pkg::CHAR_ZERO);
            if ($urandom_range(3) == 0) begin
               // Digits around the limit for this sign and setting.
               if (mode_now[tip_pkg::REG_SIGNED_MODE] && negative)
                  bound = mode_now[tip_pkg::REG_WIDE_MODE] ? tip_pkg::LIM_NEG_64
                                                           : tip_pkg::LIM_NEG_32;
               else if (!mode_now[tip_pkg::REG_SIGNED_MODE] ||
                        mode_now[tip_pkg::REG_FULL_POSITIVE_RANGE])
                  bound = mode_now[tip_pkg::REG_WIDE_MODE] ? tip_pkg::LIM_U64 : tip_pkg::LIM_U32;
               else
                  bound = mode_now[tip_pkg::REG_WIDE_MODE] ? tip_pkg::LIM_S64 : tip_pkg::LIM_S32;
               digits = mode_now[tip_pkg::REG_RADIX_HEX] ? $sformatf("%0h", bound)
                                                         : $sformatf("%0d", bound);
               for (int i = 0; i < digits.len(); i++) begin
                  c = digits[i];
                  if (c >= tip_pkg::CHAR_LOWER_A && $urandom_range(1))
                     c = c - 8'h20;
                  append_char(text, c);
               end
               case ($urandom_range(3))
                  1: text[text.size() - 1] = pick_digit();
                  2: append_char(text, pick_digit());
                  3: void'(text.pop_back());
                  default: ;
               endcase
            end else begin
               repeat ($urandom_range(9) == 0 ? $urandom_range(1, 22) : $urandom_range(1, 6))
                  append_char(text, pick_digit());
            end
            if ($urandom_range(9) == 0)
               text.insert($urandom_range(text.size()), pick_byte());
         end else if (kind < 85) begin
            repeat ($urandom_range(6)) append_char(text, pick_byte());
         end else begin
            text = from_text(broken_texts[$urandom_range(14)]);
         end
         send_text(text, $urandom_range(9) == 0);
         string_count++;
      end

      drain();
      if (mismatches == 0 && integers_due == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

[files.f]
hw/rtl/tip_pkg.sv
hw/rtl/tip_req_if.sv
hw/rtl/tip_rsp_if.sv
hw/rtl/text_to_integer_parser.sv
test/parse_result_monitor.sv
test/testbench.sv
